>>> rtl/mrbq_pkg.sv
// mrbq_pkg: shared types, constants and operation/status codes
// for the multi reader broadcast queue; no dependencies
`default_nettype none
package mrbq_pkg;
    localparam int QueueDepth = 32;
    localparam int Readers = 10;
    localparam logic [4:0] LAG_RESET = 5'd30;

    localparam logic [2:0] OP_SEND = 3'd0;
    localparam logic [2:0] OP_REGISTER = 3'd1;
    localparam logic [2:0] OP_DEREGISTER = 3'd2;
    localparam logic [2:0] OP_RECEIVE = 3'd3;
    localparam logic [2:0] OP_MARK = 3'd4;
    localparam logic [2:0] OP_AVAIL = 3'd5;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NO_READERS = 3'd1;
    localparam logic [2:0] ST_NO_SLOT = 3'd2;
    localparam logic [2:0] ST_NOT_REG = 3'd3;
    localparam logic [2:0] ST_BEYOND = 3'd4;
    localparam logic [2:0] ST_NONE = 3'd5;

    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  reader_slot;
        logic [31:0] data_handle;
        logic [23:0] data_length;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  granted_slot;
        logic [31:0] msg_id;
        logic [31:0] out_handle;
        logic [23:0] out_length;
        logic [5:0]  mail_count;
        logic [28:0] total_length;
    } out_item_t;
endpackage
`default_nettype wire

>>> rtl/multi_reader_broadcast_queue_unit.sv
// multi_reader_broadcast_queue_unit: broadcast descriptor queue, top level
// depends on mrbq_pkg and mrbq_ram
//
//  channel   ports                       handshake
//  s_        s_valid s_ready s_item      valid/ready, in_item_t
//  m_        m_valid m_ready m_item      valid/ready, out_item_t
//  cfg       cfg_we cfg_data             write strobe, max_lag
//
// each transaction passes DECODE before its result: send writes the entry, walking
// the readers first when the oldest entry is dropped for lag; receive and mark read
// the ram; register walks the slots to the first free one; deregister and available
// walk the stored entries from the reader's position; an error status goes straight out.
// one transaction at a time; s_ready returns the cycle after the result is taken.
// reset is synchronous active low, no clearing pass; only sent entries are read.
`default_nettype none
module multi_reader_broadcast_queue_unit #(
    parameter int QUEUE_DEPTH = mrbq_pkg::QueueDepth,
    parameter int READERS = mrbq_pkg::Readers
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire mrbq_pkg::in_item_t  s_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output mrbq_pkg::out_item_t      m_item,
    input  wire logic                cfg_we,
    input  wire logic [4:0]          cfg_data
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int RW = (READERS > 1) ? $clog2(READERS) : 1;
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] DEPTH_M1 = CW'(QUEUE_DEPTH - 1);
    localparam logic [RW:0] READERS_C = (RW + 1)'(READERS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_LAGWALK = 4'd2;
    localparam logic [3:0] S_WRITE = 4'd3;
    localparam logic [3:0] S_REGWALK = 4'd4;
    localparam logic [3:0] S_RDWAIT = 4'd5;
    localparam logic [3:0] S_RDDATA = 4'd6;
    localparam logic [3:0] S_MARKRD = 4'd7;
    localparam logic [3:0] S_MARKWR = 4'd8;
    localparam logic [3:0] S_WALK = 4'd9;
    localparam logic [3:0] S_OUT = 4'd10;

    logic [3:0] state_reg;
    mrbq_pkg::in_item_t in_reg;
    mrbq_pkg::out_item_t out_reg;
    logic [4:0] max_lag_reg;
    logic [31:0] oldest_id_reg, next_id_reg;
    logic [CW-1:0] stored_count_reg;
    logic [AW-1:0] head_reg;
    logic [READERS-1:0] in_use_reg;
    logic [31:0] pos_reg [READERS];
    logic [4:0] active_reg;
    logic [CW-1:0] k_reg;
    logic [RW:0] ri_reg;
    logic [31:0] id_reg;
    logic [5:0] cnt_reg;
    logic [28:0] sum_reg;
    logic rd_pend_reg;
    logic [AW-1:0] rd_slot_reg;

    logic [CW-1:0] lag;
    logic reg_ok;
    logic [31:0] pos;
    logic first_ok;
    logic [CW-1:0] first_k;
    logic [31:0] pdiff;

    logic ram_we, pend_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [55:0] ram_wdata, ram_rdata;
    logic [4:0] pend_wdata, pend_rdata;

    mrbq_ram #(.WIDTH(56), .DEPTH(QUEUE_DEPTH)) u_data (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );
    mrbq_ram #(.WIDTH(5), .DEPTH(QUEUE_DEPTH)) u_pend (
        .aclk(aclk), .we(pend_we), .waddr(ram_waddr), .wdata(pend_wdata),
        .raddr(ram_raddr), .rdata(pend_rdata)
    );

    function automatic logic [AW-1:0] slot_of(logic [AW-1:0] head, logic [CW-1:0] k);
        logic [CW:0] s;
        s = {2'b00, head} + {1'b0, k};
        if (s >= (CW + 1)'(QUEUE_DEPTH)) begin
            s = s - (CW + 1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    always_comb begin
        lag = (max_lag_reg > 5'(QUEUE_DEPTH - 1) && QUEUE_DEPTH <= 32)
            ? DEPTH_M1 : CW'(max_lag_reg);
        if (QUEUE_DEPTH > 32) begin
            lag = CW'(max_lag_reg);
        end
        reg_ok = ({1'b0, in_reg.reader_slot} < 5'(READERS))
            && in_use_reg[RW'(in_reg.reader_slot)];
        pos = ({1'b0, in_reg.reader_slot} < 5'(READERS))
            ? pos_reg[RW'(in_reg.reader_slot)] : 32'd0;
        pdiff = pos - oldest_id_reg;
        first_ok = 1'b0;
        first_k = '0;
        if (stored_count_reg != '0) begin
            if (!pdiff[31] || pdiff == 32'd0) begin
                if (pdiff < 32'(stored_count_reg)) begin
                    first_ok = 1'b1;
                    first_k = CW'(pdiff);
                end
            end
            if (((oldest_id_reg - pos) & 32'h8000_0000) == 32'd0) begin
                first_ok = 1'b1;
                first_k = '0;
            end
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_item = out_reg;

    always_comb begin
        ram_we = 1'b0;
        pend_we = 1'b0;
        ram_waddr = slot_of(head_reg, stored_count_reg);
        ram_wdata = {in_reg.data_handle, in_reg.data_length};
        pend_wdata = active_reg;
        ram_raddr = slot_of(head_reg, k_reg);
        if (state_reg == S_WRITE) begin
            ram_we = 1'b1;
            pend_we = 1'b1;
        end
        if (state_reg == S_MARKWR || (state_reg == S_WALK && rd_pend_reg)) begin
            pend_we = (state_reg == S_MARKWR) || (in_reg.operation == mrbq_pkg::OP_DEREGISTER);
            ram_waddr = rd_slot_reg;
            pend_wdata = (pend_rdata != 5'd0) ? pend_rdata - 5'd1 : 5'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            max_lag_reg <= mrbq_pkg::LAG_RESET;
            oldest_id_reg <= '0;
            next_id_reg <= '0;
            stored_count_reg <= '0;
            head_reg <= '0;
            in_use_reg <= '0;
            active_reg <= '0;
            rd_pend_reg <= 1'b0;
            for (int i = 0; i < READERS; i++) begin
                pos_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                max_lag_reg <= cfg_data;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        in_reg <= s_item;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    mrbq_pkg::out_item_t res;
                    logic [3:0] nxt;
                    logic [CW-1:0] kv;
                    res = '0;
                    nxt = S_OUT;
                    kv = first_k;
                    ri_reg <= '0;
                    cnt_reg <= '0;
                    sum_reg <= '0;
                    rd_pend_reg <= 1'b0;
                    case (in_reg.operation)
                        mrbq_pkg::OP_SEND: begin
                            if (active_reg == '0) begin
                                res.status = mrbq_pkg::ST_NO_READERS;
                            end else begin
                                id_reg <= next_id_reg;
                                res.msg_id = next_id_reg;
                                if (stored_count_reg == '0) begin
                                    oldest_id_reg <= next_id_reg;
                                    nxt = S_WRITE;
                                end else if (stored_count_reg > lag) begin
                                    head_reg <= slot_of(head_reg, CW'(1));
                                    oldest_id_reg <= oldest_id_reg + 32'd1;
                                    stored_count_reg <= stored_count_reg - CW'(1);
                                    nxt = S_LAGWALK;
                                end else begin
                                    nxt = S_WRITE;
                                end
                            end
                        end
                        mrbq_pkg::OP_REGISTER: begin
                            nxt = S_REGWALK;
                        end
                        mrbq_pkg::OP_DEREGISTER, mrbq_pkg::OP_AVAIL: begin
                            if (!reg_ok) begin
                                res.status = mrbq_pkg::ST_NOT_REG;
                            end else begin
                                if (!first_ok) begin
                                    kv = stored_count_reg;
                                end
                                nxt = S_WALK;
                            end
                        end
                        mrbq_pkg::OP_RECEIVE: begin
                            if (!reg_ok) begin
                                res.status = mrbq_pkg::ST_NOT_REG;
                            end else if (((next_id_reg - pos) & 32'h8000_0000) != 0) begin
                                res.status = mrbq_pkg::ST_BEYOND;
                            end else if (!first_ok) begin
                                res.status = mrbq_pkg::ST_NONE;
                            end else begin
                                id_reg <= oldest_id_reg + 32'(first_k);
                                nxt = S_RDWAIT;
                            end
                        end
                        mrbq_pkg::OP_MARK: begin
                            if (!reg_ok) begin
                                res.status = mrbq_pkg::ST_NOT_REG;
                            end else if (!first_ok) begin
                                res.status = mrbq_pkg::ST_NONE;
                            end else begin
                                id_reg <= oldest_id_reg + 32'(first_k);
                                nxt = S_MARKRD;
                            end
                        end
                        default: begin
                        end
                    endcase
                    out_reg <= res;
                    k_reg <= kv;
                    state_reg <= nxt;
                end
                S_LAGWALK: begin
                    if (ri_reg == READERS_C) begin
                        state_reg <= S_WRITE;
                    end else begin
                        if (in_use_reg[RW'(ri_reg)]) begin
                            logic [31:0] d, mag;
                            d = id_reg - pos_reg[RW'(ri_reg)];
                            mag = d[31] ? (32'd0 - d) : d;
                            if (mag > 32'(lag)) begin
                                pos_reg[RW'(ri_reg)] <= pos_reg[RW'(ri_reg)] + 32'd1;
                            end
                        end
                        ri_reg <= ri_reg + (RW + 1)'(1);
                    end
                end
                S_WRITE: begin
                    stored_count_reg <= stored_count_reg + CW'(1);
                    next_id_reg <= next_id_reg + 32'd1;
                    state_reg <= S_OUT;
                end
                S_REGWALK: begin
                    if (ri_reg == READERS_C) begin
                        out_reg.status <= mrbq_pkg::ST_NO_SLOT;
                        state_reg <= S_OUT;
                    end else if (!in_use_reg[RW'(ri_reg)]) begin
                        in_use_reg[RW'(ri_reg)] <= 1'b1;
                        pos_reg[RW'(ri_reg)] <= next_id_reg;
                        active_reg <= active_reg + 5'd1;
                        out_reg.granted_slot <= 4'(ri_reg);
                        state_reg <= S_OUT;
                    end else begin
                        ri_reg <= ri_reg + (RW + 1)'(1);
                    end
                end
                S_RDWAIT: begin
                    state_reg <= S_RDDATA;
                end
                S_RDDATA: begin
                    out_reg <= {mrbq_pkg::ST_OK, 4'd0, id_reg, ram_rdata, 6'd0, 29'd0};
                    state_reg <= S_OUT;
                end
                S_MARKRD: begin
                    rd_slot_reg <= ram_raddr;
                    state_reg <= S_MARKWR;
                end
                S_MARKWR: begin
                    pos_reg[RW'(in_reg.reader_slot)] <= id_reg + 32'd1;
                    if (pend_rdata <= 5'd1) begin
                        head_reg <= slot_of(head_reg, k_reg + CW'(1));
                        stored_count_reg <= stored_count_reg - (k_reg + CW'(1));
                        oldest_id_reg <= id_reg + 32'd1;
                    end
                    out_reg.msg_id <= id_reg;
                    state_reg <= S_OUT;
                end
                S_WALK: begin
                    if (rd_pend_reg) begin
                        cnt_reg <= cnt_reg + 6'd1;
                        sum_reg <= sum_reg + 29'(ram_rdata[23:0]);
                    end
                    rd_slot_reg <= ram_raddr;
                    if (k_reg < stored_count_reg) begin
                        rd_pend_reg <= 1'b1;
                        k_reg <= k_reg + CW'(1);
                    end else begin
                        rd_pend_reg <= 1'b0;
                        if (!rd_pend_reg) begin
                            if (in_reg.operation == mrbq_pkg::OP_DEREGISTER) begin
                                in_use_reg[RW'(in_reg.reader_slot)] <= 1'b0;
                                active_reg <= active_reg - 5'd1;
                            end else begin
                                out_reg <= {mrbq_pkg::ST_OK, 4'd0, 32'd0, 32'd0, 24'd0,
                                            cnt_reg, sum_reg};
                            end
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/mrbq_ram.sv
// mrbq_ram: generic simple dual port ram, one write port and one read port, with registered read
// no dependencies
`default_nettype none
module mrbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/mrbq_checker.sv
// mrbq_checker: port level assertions for the queue top level
// depends on mrbq_pkg; bound to multi_reader_broadcast_queue_unit
`default_nettype none
module mrbq_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire mrbq_pkg::out_item_t m_item
);
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");
    a_result_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !m_valid) else $error("result without work");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_item))) else $error("result dropped");
    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.status != mrbq_pkg::ST_OK) |->
        (m_item.msg_id == 32'd0 && m_item.mail_count == 6'd0))
        else $error("fields set on error");
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_item.status <= mrbq_pkg::ST_NONE)) else $error("bad status");
endmodule

bind multi_reader_broadcast_queue_unit mrbq_checker u_mrbq_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
);
`default_nettype wire
